// ===== src/dtac_pkg.sv =====
// ----------------------------------------------------------------------------
// dtac_pkg - shared types and constants for the DMS text parser
// Phase codes, parser state, result record and ASCII codes used by the
// step logic and the top level.
// ----------------------------------------------------------------------------
package dtac_pkg;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_DEG  = 5'b00001,
    PH_MIN  = 5'b00010,
    PH_SEC  = 5'b00100,
    PH_MAS  = 5'b01000,
    PH_HALT = 5'b10000
  } phase_t;

  // Field widths
  localparam int unsigned DegW    = 8;
  localparam int unsigned MinW    = 7;
  localparam int unsigned SecW    = 7;
  localparam int unsigned MasW    = 14;
  localparam int unsigned ValueW  = 21;
  localparam int unsigned StatusW = 2;
  localparam int unsigned HemiW   = 2;

  // Range limits
  localparam logic [DegW-1:0] DEG_MAX = 8'd180;
  localparam logic [MinW-1:0] MIN_MAX = 7'd59;
  localparam logic [SecW-1:0] SEC_MAX = 7'd59;
  localparam logic [MasW-1:0] MAS_MAX = 14'd9999;

  // Arcsecond weights
  localparam logic [ValueW-1:0] ASEC_PER_DEG = 21'd3600;
  localparam logic [ValueW-1:0] ASEC_PER_MIN = 21'd60;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE    = 2'd2;

  // Hemisphere codes
  localparam logic [HemiW-1:0] HEMI_N = 2'd0;
  localparam logic [HemiW-1:0] HEMI_S = 2'd1;
  localparam logic [HemiW-1:0] HEMI_E = 2'd2;
  localparam logic [HemiW-1:0] HEMI_W = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;

  // Parser state
  typedef struct packed {
    phase_t            phase;
    logic [DegW-1:0]   deg_acc;
    logic [MinW-1:0]   min_acc;
    logic [SecW-1:0]   sec_acc;
    logic [MasW-1:0]   mas_acc;
  } parse_state_t;

  // Result of one character
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] arcsec_value;
    logic [StatusW-1:0]       status;
    logic [HemiW-1:0]         hemisphere;
  } result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:   PH_DEG,
    deg_acc: '0,
    min_acc: '0,
    sec_acc: '0,
    mas_acc: '0
  };

endpackage

// ===== src/dtac_step.sv =====
// ----------------------------------------------------------------------------
// dtac_step - one character of the DMS parser
// Given the current parser state and one character, works out the next
// state and the result beat, if the character produces one.
// ----------------------------------------------------------------------------
module dtac_step (
  input  dtac_pkg::parse_state_t cur,
  input  logic [7:0]             ch,
  input  logic                   field_start,
  output dtac_pkg::parse_state_t nxt,
  output dtac_pkg::result_t      res
);

  dtac_pkg::parse_state_t      base;
  logic                        is_digit;
  logic                        is_hemi;
  logic [3:0]                  digit;
  logic [11:0]                 deg_sum;
  logic [10:0]                 min_sum;
  logic [10:0]                 sec_sum;
  logic [17:0]                 mas_sum;
  logic [dtac_pkg::DegW-1:0]   deg_sat;
  logic [dtac_pkg::MinW-1:0]   min_sat;
  logic [dtac_pkg::SecW-1:0]   sec_sat;
  logic [dtac_pkg::MasW-1:0]   mas_sat;
  logic [dtac_pkg::HemiW-1:0]  hemi;
  logic                        out_of_range;
  logic [dtac_pkg::ValueW-1:0] total;
  logic [dtac_pkg::ValueW-1:0] signed_total;

  // Restart on a start flag
  assign base = field_start ? dtac_pkg::STATE_CLEAR : cur;

  // Classify the character
  assign is_digit = (ch >= dtac_pkg::CH_ZERO) && (ch <= dtac_pkg::CH_NINE);
  assign digit    = 4'(ch - dtac_pkg::CH_ZERO);
  assign is_hemi  = (ch == dtac_pkg::CH_N) || (ch == dtac_pkg::CH_S) ||
                    (ch == dtac_pkg::CH_E) || (ch == dtac_pkg::CH_W);

  always_comb begin
    unique case (ch)
      dtac_pkg::CH_S: hemi = dtac_pkg::HEMI_S;
      dtac_pkg::CH_E: hemi = dtac_pkg::HEMI_E;
      dtac_pkg::CH_W: hemi = dtac_pkg::HEMI_W;
      default:        hemi = dtac_pkg::HEMI_N;
    endcase
  end

  // Decimal accumulate, saturating at all ones
  assign deg_sum = 12'(base.deg_acc) * 12'd10 + 12'(digit);
  assign min_sum = 11'(base.min_acc) * 11'd10 + 11'(digit);
  assign sec_sum = 11'(base.sec_acc) * 11'd10 + 11'(digit);
  assign mas_sum = 18'(base.mas_acc) * 18'd10 + 18'(digit);

  assign deg_sat = (deg_sum > 12'd255)    ? '1 : deg_sum[dtac_pkg::DegW-1:0];
  assign min_sat = (min_sum > 11'd127)    ? '1 : min_sum[dtac_pkg::MinW-1:0];
  assign sec_sat = (sec_sum > 11'd127)    ? '1 : sec_sum[dtac_pkg::SecW-1:0];
  assign mas_sat = (mas_sum > 18'd16383)  ? '1 : mas_sum[dtac_pkg::MasW-1:0];

  // Range check and arcsecond total
  assign out_of_range = (base.deg_acc > dtac_pkg::DEG_MAX) ||
                        (base.min_acc > dtac_pkg::MIN_MAX) ||
                        (base.sec_acc > dtac_pkg::SEC_MAX) ||
                        (base.mas_acc > dtac_pkg::MAS_MAX);

  assign total = dtac_pkg::ValueW'(base.deg_acc) * dtac_pkg::ASEC_PER_DEG +
                 dtac_pkg::ValueW'(base.min_acc) * dtac_pkg::ASEC_PER_MIN +
                 dtac_pkg::ValueW'(base.sec_acc);

  assign signed_total = ((hemi == dtac_pkg::HEMI_S) || (hemi == dtac_pkg::HEMI_W)) ?
                        (dtac_pkg::ValueW'(0) - total) : total;

  // Next state and result
  always_comb begin
    nxt              = base;
    res.valid        = 1'b0;
    res.arcsec_value = '0;
    res.status       = dtac_pkg::ST_OK;
    res.hemisphere   = dtac_pkg::HEMI_N;

    priority if (base.phase == dtac_pkg::PH_HALT) begin
      // ignore until the next start
    end else if (is_digit) begin
      unique case (base.phase)
        dtac_pkg::PH_DEG: nxt.deg_acc = deg_sat;
        dtac_pkg::PH_MIN: nxt.min_acc = min_sat;
        dtac_pkg::PH_SEC: nxt.sec_acc = sec_sat;
        dtac_pkg::PH_MAS: nxt.mas_acc = mas_sat;
        default: ;
      endcase
    end else if (ch == dtac_pkg::CH_HYPHEN && base.phase == dtac_pkg::PH_DEG) begin
      nxt.phase = dtac_pkg::PH_MIN;
    end else if (ch == dtac_pkg::CH_HYPHEN && base.phase == dtac_pkg::PH_MIN) begin
      nxt.phase = dtac_pkg::PH_SEC;
    end else if (ch == dtac_pkg::CH_PERIOD && base.phase == dtac_pkg::PH_SEC) begin
      nxt.phase = dtac_pkg::PH_MAS;
    end else if (is_hemi && base.phase == dtac_pkg::PH_MAS) begin
      nxt.phase      = dtac_pkg::PH_HALT;
      res.valid      = 1'b1;
      res.hemisphere = hemi;
      if (out_of_range) begin
        res.status = dtac_pkg::ST_RANGE;
      end else begin
        res.arcsec_value = signed_total;
      end
    end else begin
      nxt.phase  = dtac_pkg::PH_HALT;
      res.valid  = 1'b1;
      res.status = dtac_pkg::ST_BAD_CHAR;
    end
  end

endmodule

// ===== src/dms_text_to_arcseconds_core.sv =====
// ----------------------------------------------------------------------------
// dms_text_to_arcseconds_core - DMS coordinate text to signed arcseconds
// Parses DDD-MM-SS.MMMMH one character per beat and returns the total.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and keeps taking characters as long
// as its single output register is empty or being drained in the same cycle;
// the parser state register advances on each accepted beat, and a result is
// registered in the cycle after the hemisphere letter or the offending character.
// Set the tuser flag on the first character of each string to restart the
// parser. After any result, good or bad, characters give nothing until the
// next start. Results carry arcseconds (degrees*3600 + minutes*60 + seconds,
// negated for S and W), a status (0 ok, 1 bad character, 2 out of range) and
// the hemisphere; milliarcseconds are range-checked only.
module dms_text_to_arcseconds_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] field_start
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] arcsec_value, [22:21] hemisphere, [23] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  dtac_pkg::parse_state_t st;
  dtac_pkg::parse_state_t st_next;
  dtac_pkg::result_t      res;
  logic                   accept;

  // Take a beat whenever the output register can take its result
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  dtac_step u_step (
    .cur         (st),
    .ch          (s_tdata),
    .field_start (s_tuser),
    .nxt         (st_next),
    .res         (res)
  );

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= dtac_pkg::STATE_CLEAR;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Output register: drop on take, load on a new result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept && res.valid) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      m_tdata <= {1'b0, res.hemisphere, res.arcsec_value};
      m_tuser <= res.status;
    end
  end

endmodule

// ===== tb/arcsec_checker.sv =====
// ----------------------------------------------------------------------------
// arcsec_checker - result predictor and comparator for the DMS text parser
// Watches both stream channels, tracks the parser on every accepted input
// beat, queues the fix it expects and checks each result beat field by field.
// ----------------------------------------------------------------------------
module arcsec_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] ch
  input  logic              s_tuser,   // [0] field_start
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [23:0]       m_tdata,   // [20:0] arcsec_value, [22:21] hemisphere, [23] zero
  input  logic [1:0]        m_tuser,   // [1:0] status
  output int unsigned       mismatches,
  output int unsigned       pending,
  output int unsigned       fixes_ok,
  output int unsigned       fixes_bad_char,
  output int unsigned       fixes_range
);

  // One expected result beat
  typedef struct packed {
    logic [dtac_pkg::ValueW-1:0]  value;
    logic [dtac_pkg::StatusW-1:0] status;
    logic [dtac_pkg::HemiW-1:0]   hemi;
  } fix_t;

  fix_t fix_q[$];
  fix_t want;

  // Parser shadow state
  dtac_pkg::phase_t          ph;
  logic [dtac_pkg::DegW-1:0] deg;
  logic [dtac_pkg::MinW-1:0] mins;
  logic [dtac_pkg::SecW-1:0] secs;
  logic [dtac_pkg::MasW-1:0] mas;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned push_digit(input int unsigned acc, input int unsigned d,
                                             input int unsigned top);
    int unsigned v;
    v = acc * 10 + d;
    return (v > top) ? top : v;
  endfunction

  task automatic clear_parser();
    ph   = dtac_pkg::PH_DEG;
    deg  = '0;
    mins = '0;
    secs = '0;
    mas  = '0;
  endtask

  // Advance the shadow parser by one character, queue a fix if one is due
  task automatic parse_char(input logic [7:0] c, input logic start);
    fix_t                        f;
    logic [dtac_pkg::HemiW-1:0]  h;
    logic [dtac_pkg::ValueW-1:0] total;
    int unsigned                 d;
    if (start) clear_parser();
    if (ph == dtac_pkg::PH_HALT) return;
    // digits accumulate into the open field, saturating
    if (c >= dtac_pkg::CH_ZERO && c <= dtac_pkg::CH_NINE) begin
      d = 32'(c - dtac_pkg::CH_ZERO);
      case (ph)
        dtac_pkg::PH_DEG:
          deg  = dtac_pkg::DegW'(push_digit(deg, d, 2**dtac_pkg::DegW - 1));
        dtac_pkg::PH_MIN:
          mins = dtac_pkg::MinW'(push_digit(mins, d, 2**dtac_pkg::MinW - 1));
        dtac_pkg::PH_SEC:
          secs = dtac_pkg::SecW'(push_digit(secs, d, 2**dtac_pkg::SecW - 1));
        default:
          mas  = dtac_pkg::MasW'(push_digit(mas, d, 2**dtac_pkg::MasW - 1));
      endcase
      return;
    end
    // legal separators move to the next field
    if (c == dtac_pkg::CH_HYPHEN && ph == dtac_pkg::PH_DEG) begin
      ph = dtac_pkg::PH_MIN;
      return;
    end
    if (c == dtac_pkg::CH_HYPHEN && ph == dtac_pkg::PH_MIN) begin
      ph = dtac_pkg::PH_SEC;
      return;
    end
    if (c == dtac_pkg::CH_PERIOD && ph == dtac_pkg::PH_SEC) begin
      ph = dtac_pkg::PH_MAS;
      return;
    end
    // hemisphere letter closes the string; anything else is a bad character
    if (ph == dtac_pkg::PH_MAS && (c == dtac_pkg::CH_N || c == dtac_pkg::CH_S ||
                                   c == dtac_pkg::CH_E || c == dtac_pkg::CH_W)) begin
      case (c)
        dtac_pkg::CH_N: h = dtac_pkg::HEMI_N;
        dtac_pkg::CH_S: h = dtac_pkg::HEMI_S;
        dtac_pkg::CH_E: h = dtac_pkg::HEMI_E;
        default:        h = dtac_pkg::HEMI_W;
      endcase
      f.hemi = h;
      if (deg > dtac_pkg::DEG_MAX || mins > dtac_pkg::MIN_MAX ||
          secs > dtac_pkg::SEC_MAX || mas > dtac_pkg::MAS_MAX) begin
        f.value  = '0;
        f.status = dtac_pkg::ST_RANGE;
      end else begin
        total = dtac_pkg::ASEC_PER_DEG * deg + dtac_pkg::ASEC_PER_MIN * mins + secs;
        if (h == dtac_pkg::HEMI_S || h == dtac_pkg::HEMI_W) total = -total;
        f.value  = total;
        f.status = dtac_pkg::ST_OK;
      end
    end else begin
      f.value  = '0;
      f.status = dtac_pkg::ST_BAD_CHAR;
      f.hemi   = dtac_pkg::HEMI_N;
    end
    fix_q.push_back(f);
    ph = dtac_pkg::PH_HALT;
  endtask

  // Check the output beat against the oldest fix, then track the input beat
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      fix_q.delete();
      mismatches     = 0;
      fixes_ok       = 0;
      fixes_bad_char = 0;
      fixes_range    = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (fix_q.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing expected, tdata %h tuser %h",
                                  m_tdata, m_tuser));
        end else begin
          want = fix_q.pop_front();
          if (m_tdata[20:0] !== want.value)
            flag_mismatch($sformatf("arcsec_value got %0d want %0d",
                                    $signed(m_tdata[20:0]), $signed(want.value)));
          if (m_tuser !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", m_tuser, want.status));
          if (m_tdata[22:21] !== want.hemi)
            flag_mismatch($sformatf("hemisphere got %0d want %0d",
                                    m_tdata[22:21], want.hemi));
          if (m_tdata[23] !== 1'b0)
            flag_mismatch($sformatf("tdata pad bit got %b want 0", m_tdata[23]));
          case (want.status)
            dtac_pkg::ST_OK:       fixes_ok++;
            dtac_pkg::ST_BAD_CHAR: fixes_bad_char++;
            default:               fixes_range++;
          endcase
        end
      end
      if (s_tvalid && s_tready) parse_char(s_tdata, s_tuser);
    end
    pending = fix_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - stream testbench for dms_text_to_arcseconds_core
// Sends directed and random coordinate strings with random source and sink
// stalls; the checker predicts every fix and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] ch
  logic        s_tuser  = 1'b0; // [0] field_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [20:0] arcsec_value, [22:21] hemisphere, [23] zero
  logic [1:0]  m_tuser;         // [1:0] status

  int unsigned mismatches, pending, fixes_ok, fixes_bad_char, fixes_range;
  int unsigned src_idle  = 9;
  int unsigned sink_idle = 45;
  int unsigned chars_sent, strings_sent, noise_sent;

  logic [7:0] text_q[$];

  dms_text_to_arcseconds_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  arcsec_checker fix_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatches     (mismatches),
    .pending        (pending),
    .fixes_ok       (fixes_ok),
    .fixes_bad_char (fixes_bad_char),
    .fixes_range    (fixes_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random sink stalls, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle);
  end

  // Run-time limit
  initial begin
    #2_000_000;
    $display("dms_text_to_arcseconds_core verification failed");
    $finish;
  end

  // Drive one character beat, with random source gaps ahead of it
  task automatic send_char(input logic [7:0] c, input logic start);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == 0);
    strings_sent++;
    chars_sent += text_q.size();
  endtask

  task automatic load_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Append val as decimal digits, zero-padded to pad digits (0 and no pad: empty)
  task automatic add_number(input int unsigned val, input int unsigned pad);
    int unsigned digits[$];
    while (val > 0) begin
      digits.push_front(val % 10);
      val = val / 10;
    end
    while (digits.size() < pad) digits.push_front(0);
    foreach (digits[i]) text_q.push_back(8'(dtac_pkg::CH_ZERO + digits[i]));
  endtask

  // Mostly in range; sometimes just over the limit or an overlong digit run
  task automatic add_field(input int unsigned limit);
    int unsigned mode;
    mode = $urandom_range(19);
    if (mode == 0) begin
      repeat ($urandom_range(7, 4))
        text_q.push_back(8'(dtac_pkg::CH_ZERO + $urandom_range(9)));
    end else if (mode == 1) begin
      add_number($urandom_range(2 * limit + 1, limit + 1), 0);
    end else begin
      add_number($urandom_range(limit), $urandom_range(2));
    end
  endtask

  // One random string: well-formed, broken by a wrong character, cut short,
  // or a burst of noise
  task automatic random_string();
    logic [7:0]  hemi_chars[4];
    logic [7:0]  wrong_chars[6];
    int unsigned kind, cut;
    hemi_chars  = '{dtac_pkg::CH_N, dtac_pkg::CH_S, dtac_pkg::CH_E, dtac_pkg::CH_W};
    wrong_chars = '{dtac_pkg::CH_HYPHEN, dtac_pkg::CH_PERIOD, dtac_pkg::CH_N,
                    dtac_pkg::CH_S, dtac_pkg::CH_E, dtac_pkg::CH_W};
    kind = $urandom_range(99);
    if (kind >= 90) begin
      repeat ($urandom_range(4, 1)) begin
        send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
        noise_sent++;
      end
      return;
    end
    text_q.delete();
    add_field(dtac_pkg::DEG_MAX);
    text_q.push_back(dtac_pkg::CH_HYPHEN);
    add_field(dtac_pkg::MIN_MAX);
    text_q.push_back(dtac_pkg::CH_HYPHEN);
    add_field(dtac_pkg::SEC_MAX);
    text_q.push_back(dtac_pkg::CH_PERIOD);
    add_field(dtac_pkg::MAS_MAX);
    text_q.push_back(hemi_chars[2'($urandom_range(3))]);
    if (kind >= 65) begin
      // drop the tail; a wrong character or the next start takes over
      cut = $urandom_range(text_q.size() - 1, (kind >= 78) ? 1 : 0);
      while (text_q.size() > cut) void'(text_q.pop_back());
      if (kind < 78) begin
        if ($urandom_range(1)) text_q.push_back(wrong_chars[$urandom_range(5)]);
        else text_q.push_back(8'($urandom_range(255)));
      end
    end
    send_text();
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned target;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: widest legal value, range error with empty fields, wrong characters
    load_text("180-59-59.9999W");
    send_text();
    load_text("181--.E");
    send_text();
    text_q = '{8'hFF};
    send_text();
    send_char("7", 1'b0);  // halted: ignored
    noise_sent++;
    load_text("-N");
    send_text();
    load_text(".");
    send_text();

    // random strings under three stall mixes
    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin src_idle = 9;  sink_idle = 45; end
        1: begin src_idle = 45; sink_idle = 9;  end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      target = chars_sent + 230;
      while (chars_sent < target) random_string();
    end

    // drain
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d strings (%0d characters) plus %0d noise characters over three stall mixes.",
             strings_sent, chars_sent, noise_sent);
    $display("Fixes checked: %0d good, %0d bad character, %0d out of range.",
             fixes_ok, fixes_bad_char, fixes_range);
    if (mismatches == 0 && pending == 0) begin
      $display("dms_text_to_arcseconds_core verification clean");
    end else begin
      $display("dms_text_to_arcseconds_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dtac_pkg.sv
src/dtac_step.sv
src/dms_text_to_arcseconds_core.sv
tb/arcsec_checker.sv
tb/tb_top.sv
